// ===== rtl/sbm_pkg.sv =====
// Shared types, constants and codes for the SCCB bit-level master.
`timescale 1ns / 1ps

package sbm_pkg;

    // Delay counter width and configuration register width
    localparam int DELAY_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_DELAY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_DELAY  = 1'b1;

    // Reset values of the delay registers
    localparam logic [CFG_W-1:0] SHORT_DELAY_RST = 16'd10;
    localparam logic [CFG_W-1:0] LONG_DELAY_RST  = 16'd50;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 16;

    // Command / active operation codes
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_NOACK = 3'd4,
        OP_IDLE  = 3'd7
    } t_op;

    // Largest legal command code
    localparam logic [2:0] KIND_MAX = 3'd4;

    // Per-tick result of the sequencer
    typedef struct packed {
        logic [7:0] read_data;
        logic       acked;
        logic       done;
        logic       busy;
        logic       sda_is_input;
        logic       sda_level;
        logic       scl_level;
    } t_res;

endpackage

// ===== rtl/sbm_seq.sv =====
// Pin-phase sequencer: advances one tick per accepted beat and builds the tick result.
`timescale 1ns / 1ps

module sbm_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_cmd_valid,
    input  logic [2:0]                 i_kind,
    input  logic [7:0]                 i_write_data,
    input  logic                       i_sda_in,
    input  logic [sbm_pkg::CFG_W-1:0]  i_short_delay,
    input  logic [sbm_pkg::CFG_W-1:0]  i_long_delay,
    output sbm_pkg::t_res              o_res
);
    import sbm_pkg::*;

    localparam logic [32:0] CNT_MAX = (33'd1 << DELAY_W) - 33'd1;

    t_op                r_op,    n_op;
    logic [2:0]         r_phase, n_phase;
    logic [2:0]         r_bit,   n_bit;
    logic [7:0]         r_shift, n_shift;
    logic [DELAY_W-1:0] r_wait,  n_wait;
    logic               r_scl,   n_scl;
    logic               r_sda,   n_sda;
    logic               r_dir,   n_dir;
    logic               r_ack,   n_ack;

    logic               do_apply;
    logic               use_long;
    logic               done;
    logic               acked;
    logic [7:0]         rdata;
    logic [CFG_W-1:0]   dly;
    logic [CFG_W-1:0]   dly_m1;
    logic [32:0]        dly_clamp;

    // Step the sequence: count down, advance phase, finish or start a command
    always_comb begin
        n_op     = r_op;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_dir    = r_dir;
        n_ack    = r_ack;
        do_apply = 1'b0;
        done     = 1'b0;
        acked    = 1'b0;
        rdata    = 8'd0;

        if (r_op != OP_IDLE) begin
            if (r_wait != '0) begin
                n_wait = r_wait - 1'b1;
            end else begin
                do_apply = 1'b1;
                unique case (r_op)
                    OP_STOP: begin
                        if (r_phase >= 3'd2) do_apply = 1'b0;
                        else n_phase = r_phase + 3'd1;
                    end
                    OP_WRITE: begin
                        if (r_phase == 3'd2) begin
                            if (r_bit != 3'd7) begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = 3'd0;
                            end else begin
                                n_phase = 3'd3;
                            end
                        end else if (r_phase >= 3'd6) begin
                            do_apply = 1'b0;
                        end else begin
                            n_phase = r_phase + 3'd1;
                        end
                    end
                    OP_READ: begin
                        if (r_phase == 3'd3) begin
                            if (r_bit != 3'd7) begin
                                n_bit   = r_bit + 3'd1;
                                n_phase = 3'd1;
                            end else begin
                                do_apply = 1'b0;
                            end
                        end else begin
                            n_phase = r_phase + 3'd1;
                        end
                    end
                    default: begin
                        // start and no-ack share a four-phase list
                        if (r_phase >= 3'd3) do_apply = 1'b0;
                        else n_phase = r_phase + 3'd1;
                    end
                endcase

                // End of sequence: release the bus turnaround and report
                if (!do_apply) begin
                    if (r_op == OP_WRITE) begin
                        n_dir = 1'b0;
                        acked = r_ack;
                    end
                    if (r_op == OP_READ) begin
                        n_dir = 1'b0;
                        rdata = r_shift;
                    end
                    done    = 1'b1;
                    n_op    = OP_IDLE;
                    n_phase = 3'd0;
                    n_bit   = 3'd0;
                end
            end
        end else if (i_cmd_valid && (i_kind <= KIND_MAX)) begin
            n_op     = t_op'(i_kind);
            n_phase  = 3'd0;
            n_bit    = 3'd0;
            n_ack    = 1'b0;
            n_shift  = (t_op'(i_kind) == OP_WRITE) ? i_write_data : 8'd0;
            do_apply = 1'b1;
        end

        // Apply the pin action of the new phase
        use_long = 1'b0;
        if (do_apply) begin
            unique case (n_op)
                OP_START: begin
                    unique case (n_phase)
                        3'd0:    n_sda = 1'b1;
                        3'd1:    n_scl = 1'b1;
                        3'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    unique case (n_phase)
                        3'd0:    n_sda = 1'b0;
                        3'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                OP_NOACK: begin
                    unique case (n_phase)
                        3'd0:    n_sda = 1'b1;
                        3'd1:    n_scl = 1'b1;
                        3'd2:    n_scl = 1'b0;
                        default: n_sda = 1'b0;
                    endcase
                end
                OP_WRITE: begin
                    unique case (n_phase)
                        3'd0: n_sda = n_shift[3'd7 - n_bit];
                        3'd1: n_scl = 1'b1;
                        3'd2: n_scl = 1'b0;
                        3'd4: begin
                            n_dir    = 1'b1;
                            use_long = 1'b1;
                        end
                        3'd5: begin
                            n_scl    = 1'b1;
                            use_long = 1'b1;
                        end
                        3'd6: begin
                            n_ack = ~i_sda_in;
                            n_scl = 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_READ: begin
                    unique case (n_phase)
                        3'd0: n_dir = 1'b1;
                        3'd2: n_scl = 1'b1;
                        3'd3: begin
                            n_shift = {n_shift[6:0], i_sda_in};
                            n_scl   = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // Load the hold: zero counts as one tick, clamp to the counter range
        dly       = use_long ? i_long_delay : i_short_delay;
        dly_m1    = (dly == '0) ? '0 : dly - 1'b1;
        dly_clamp = ({17'd0, dly_m1} > CNT_MAX) ? CNT_MAX : {17'd0, dly_m1};
        if (do_apply) n_wait = dly_clamp[DELAY_W-1:0];
    end

    // Hold sequencer state, advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_IDLE;
            r_phase <= 3'd0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_wait  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_dir   <= 1'b0;
            r_ack   <= 1'b0;
        end else if (i_step) begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_wait  <= n_wait;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_dir   <= n_dir;
            r_ack   <= n_ack;
        end
    end

    // Result of this tick
    always_comb begin
        o_res.scl_level    = n_scl;
        o_res.sda_level    = n_sda;
        o_res.sda_is_input = n_dir;
        o_res.busy         = (n_op != OP_IDLE);
        o_res.done         = done;
        o_res.acked        = acked;
        o_res.read_data    = rdata;
    end

    // An idle sequencer holds no pending count and sits at its first phase
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == OP_IDLE) |-> (r_wait == '0 && r_phase == 3'd0 && r_bit == 3'd0))
        else $error("sbm_seq: idle with leftover phase or count");

    // SDA is released only inside a write or a read
    a_dir_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir |-> (r_op == OP_WRITE || r_op == OP_READ))
        else $error("sbm_seq: SDA released outside write or read");

    // A finishing tick always returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |=> (r_op == OP_IDLE))
        else $error("sbm_seq: done without returning to idle");

endmodule

// ===== rtl/sccb_bit_level_master.sv =====
// The result of a tick beat is registered and appears on the master side in the cycle after it is taken.
// Throughput: one tick beat per cycle while the output slot is free or drains in the same cycle;
// a held result that the master side does not take stalls the next beat.
// Each tick beat yields exactly one result beat.
// Reset is synchronous, active low: delays return to 10 and 50 ticks, bus lines released.
`timescale 1ns / 1ps

module sccb_bit_level_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [sbm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sbm_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Tick input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] write_data, [8] sda_in, [15:9] zero
    input  logic [sbm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] cmd_valid, [3:1] kind
    input  logic [sbm_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // Tick result
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_is_input, [3] busy_res, [4] done_res,
    // [5] acked, [13:6] read_data, [15:14] zero
    output logic [sbm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import sbm_pkg::*;

    logic [CFG_W-1:0] r_short_delay;
    logic [CFG_W-1:0] r_long_delay;
    logic             r_out_valid;
    t_res             r_out;
    t_res             seq_res;
    logic             step;

    // Take a beat whenever the output slot is free or drains this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    // Delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_delay <= SHORT_DELAY_RST;
            r_long_delay  <= LONG_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SHORT_DELAY: r_short_delay <= i_cfg_wdata;
                REG_LONG_DELAY:  r_long_delay  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sbm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cmd_valid   (s_axis_tuser[0]),
        .i_kind        (s_axis_tuser[3:1]),
        .i_write_data  (s_axis_tdata[7:0]),
        .i_sda_in      (s_axis_tdata[8]),
        .i_short_delay (r_short_delay),
        .i_long_delay  (r_long_delay),
        .o_res         (seq_res)
    );

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= seq_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.read_data, r_out.acked, r_out.done, r_out.busy,
                            r_out.sda_is_input, r_out.sda_level, r_out.scl_level};

    // A completing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> !r_out.busy)
        else $error("sccb_bit_level_master: done together with busy");

    // Ack is only reported on a completing tick
    a_ack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.acked) |-> r_out.done)
        else $error("sccb_bit_level_master: ack outside completion");

    // Read data is only nonzero on a completing tick
    a_rdata_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_data != 8'd0) |-> r_out.done)
        else $error("sccb_bit_level_master: read data outside completion");

endmodule
